// ===== hdl/mexp_pkg.sv =====
// Shared widths, operation codes, controller states and the command and
// status structs for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int DATA_W   = 31;
  localparam int EXP_W    = 63;
  localparam int EXP_BITS = 63;
  localparam int STEP_W   = $clog2(DATA_W + 1);
  localparam int BCNT_W   = $clog2(EXP_BITS + 1);

  typedef enum logic [1:0] {
    OP_RED = 2'd0,
    OP_ACC = 2'd1,
    OP_SQR = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_STEP  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
    logic step;
    logic commit;
    logic shift_exp;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic exp_lsb;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/mexp_if.sv =====
// Valid/ready channels for the operand beat and the result beat.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mexp_in_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base;
  logic [EXP_W-1:0]  exponent;
  logic [DATA_W-1:0] modulus;

  modport source (output valid, base, exponent, modulus, input ready);
  modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] power_mod;

  modport source (output valid, power_mod, input ready);
  modport sink (input valid, power_mod, output ready);
endinterface

`default_nettype wire

// ===== hdl/mexp_datapath.sv =====
// Operand registers, running square and accumulator, and the shared
// shift-add modular multiplier (one multiplier bit per cycle).
// Depends on mexp_pkg; driven by mexp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mexp_datapath import mexp_pkg::*; (
  input  wire logic              clk,
  input  wire logic [DATA_W-1:0] base,
  input  wire logic [EXP_W-1:0]  exponent,
  input  wire logic [DATA_W-1:0] modulus,
  input  wire cmd_t              cmd,
  output stat_t                  status,
  output logic      [DATA_W-1:0] power_mod
);

  logic [DATA_W-1:0] base_q;
  logic [EXP_W-1:0]  exp_q;
  logic [DATA_W-1:0] m_q;
  logic              mzero;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sq;
  logic [DATA_W-1:0] r;
  logic [DATA_W-1:0] x;
  logic [DATA_W-1:0] y;
  logic [DATA_W-1:0] one_mod;
  logic [DATA_W-1:0] one_mod_in;

  logic [DATA_W:0]   dbl;
  logic [DATA_W:0]   dbl_red;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   m_ext;
  logic [DATA_W-1:0] r_next;

  assign one_mod    = (m_q == DATA_W'(1)) ? '0 : DATA_W'(1);
  assign one_mod_in = (modulus == DATA_W'(1)) ? '0 : DATA_W'(1);

  // r <- (2r + bit * x) mod m, with r and x below m
  always_comb begin
    m_ext   = {1'b0, m_q};
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = {1'b0, dbl_red[DATA_W-1:0]} + (y[DATA_W-1] ? {1'b0, x} : '0);
    r_next  = (sum >= m_ext) ? DATA_W'(sum - m_ext) : sum[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_q <= base;
      exp_q  <= exponent;
      m_q    <= modulus;
      mzero  <= (modulus == '0);
      acc    <= one_mod_in;
    end
    if (cmd.start) begin
      r <= '0;
      case (cmd.op)
        OP_RED: begin
          x <= one_mod;
          y <= base_q;
        end
        OP_ACC: begin
          x <= acc;
          y <= sq;
        end
        OP_SQR: begin
          x <= sq;
          y <= sq;
        end
        default: begin
          x <= '0;
          y <= '0;
        end
      endcase
    end
    if (cmd.step) begin
      r <= r_next;
      y <= {y[DATA_W-2:0], 1'b0};
    end
    if (cmd.commit) begin
      case (cmd.op)
        OP_RED:  sq  <= r_next;
        OP_SQR:  sq  <= r_next;
        OP_ACC:  acc <= r_next;
        default: acc <= acc;
      endcase
    end
    if (cmd.shift_exp) begin
      exp_q <= {1'b0, exp_q[EXP_W-1:1]};
    end
    if (cmd.publish) begin
      power_mod <= mzero ? '0 : acc;
    end
  end

  assign status.exp_lsb = exp_q[0];

endmodule

`default_nettype wire

// ===== hdl/mexp_ctrl.sv =====
// Sequencer: reduce the base, then per exponent bit an optional multiply
// and a square, each a pass of the shared multiplier; owns the handshakes.
// Depends on mexp_pkg; drives mexp_datapath.
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl import mexp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  op_valid,
  output logic       op_ready,
  output logic       res_valid,
  input  wire logic  res_ready,
  input  wire stat_t status,
  output cmd_t       cmd
);

  state_t            state;
  state_t            state_next;
  op_t               cur_op;
  op_t               cur_op_next;
  op_t               go_op;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;
  logic [BCNT_W-1:0] bcnt;
  logic [BCNT_W-1:0] bcnt_next;
  logic              res_valid_next;

  assign op_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cur_op_next = cur_op;
    cnt_next    = cnt;
    bcnt_next   = bcnt;
    cmd         = '0;
    cmd.op      = cur_op;
    go_op       = (cur_op == OP_ACC && !status.exp_lsb) ? OP_SQR : cur_op;
    case (state)
      S_IDLE: begin
        if (op_valid) begin
          cmd.load    = 1'b1;
          cur_op_next = OP_RED;
          bcnt_next   = '0;
          state_next  = S_START;
        end
      end
      S_START: begin
        cmd.start   = 1'b1;
        cmd.op      = go_op;
        cur_op_next = go_op;
        cnt_next    = '0;
        state_next  = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        cnt_next = cnt + STEP_W'(1);
        if (cnt == STEP_W'(DATA_W - 1)) begin
          cmd.commit = 1'b1;
          case (cur_op)
            OP_RED: begin
              cur_op_next = OP_ACC;
              state_next  = S_START;
            end
            OP_ACC: begin
              cur_op_next = OP_SQR;
              state_next  = S_START;
            end
            OP_SQR: begin
              cmd.shift_exp = 1'b1;
              if (bcnt == BCNT_W'(EXP_BITS - 1)) begin
                state_next = S_FIN;
              end else begin
                bcnt_next   = bcnt + BCNT_W'(1);
                cur_op_next = OP_ACC;
                state_next  = S_START;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FIN: begin
        if (!res_valid || res_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res_valid_next = cmd.publish ? 1'b1 : (res_ready ? 1'b0 : res_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_op    <= OP_RED;
      cnt       <= '0;
      bcnt      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_op    <= cur_op_next;
      cnt       <= cnt_next;
      bcnt      <= bcnt_next;
      res_valid <= res_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!res_valid || res_ready))
    else $error("result overwritten while held");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready) |=> (state == S_START && cur_op == OP_RED))
    else $error("accepted beat did not start the base reduction");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (cnt <= STEP_W'(DATA_W - 1)))
    else $error("multiplier step count out of range");

  a_bcnt_range: assert property (@(posedge clk) disable iff (rst)
    bcnt <= BCNT_W'(EXP_BITS - 1))
    else $error("exponent bit count out of range");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> res_valid)
    else $error("result published without valid");

endmodule

`default_nettype wire

// ===== hdl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: joins the sequencer and
// the datapath. Depends on mexp_pkg, mexp_if, mexp_ctrl, mexp_datapath.
// Usage:
//   operands: sink channel carrying base, exponent and modulus. A beat is
//     taken when valid and ready are both high; ready is high only while
//     the block is idle, so one item is worked at a time.
//   result: source channel carrying power_mod, base^exponent mod modulus.
//     A modulus of zero returns zero.
// Operation:
//   Every modular multiply is one pass of a shared shift-add unit that
//   handles one multiplier bit per cycle, after a launch state for the pass.
//   The base is reduced by one pass, then each of the 63 exponent bits
//   takes a square pass, plus a multiply pass where the bit is set.
//   Operand ready returns high in the same cycle as result valid, so the
//   next beat can then be taken.
// Reset: rst (synchronous, active high) returns the sequencer to idle and
//   drops result valid; any item in progress is lost.
// Stall: a finished result waits in the output register while ready is
//   low; the block takes the next item meanwhile and holds its own result
//   until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation import mexp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mexp_in_if.sink   operands,
  mexp_out_if.source result
);

  cmd_t  cmd;
  stat_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (operands.valid),
    .op_ready  (operands.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath u_datapath (
    .clk       (clk),
    .base      (operands.base),
    .exponent  (operands.exponent),
    .modulus   (operands.modulus),
    .cmd       (cmd),
    .status    (status),
    .power_mod (result.power_mod)
  );

endmodule

`default_nettype wire
